// ----- hdl/nau_pkg.sv -----
package nau_pkg;

  // number format and table geometry
  localparam int FRAC_BITS      = 12;
  localparam int TABLE_SEGMENTS = 128;
  localparam int SEG_BITS       = FRAC_BITS + 3;
  localparam int DATA_W         = 16;
  localparam int KIND_W         = 2;
  localparam int MODE_W         = 2;
  localparam int ENTRY_W        = 17;
  localparam int ROM_AW         = $clog2(TABLE_SEGMENTS + 1);
  localparam int IDX_W          = $clog2(TABLE_SEGMENTS);
  localparam int AX_W           = (SEG_BITS + 1 > 17) ? SEG_BITS + 1 : 17;
  localparam int POS_W          = AX_W + ROM_AW;
  localparam int MUL_W          = 32;
  localparam int PROD_W         = 64;

  // queue between front and back, and result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int OUTQ_DEPTH  = 16;
  localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

  // function_kind register codes
  localparam logic [KIND_W-1:0] KIND_SIGMOID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TANH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELU    = 2'd2;

  // item mode codes
  localparam logic [MODE_W-1:0] MODE_APPLY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DX    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DY    = 2'd2;

  // operation picked by the front for the back
  typedef enum logic [2:0] {
    OP_SIG_F,   // sigmoid of x
    OP_SIG_D,   // sigmoid derivative at x
    OP_TANH_F,  // tanh of x
    OP_TANH_D,  // tanh derivative at x
    OP_SIG_Y,   // y(1-y) from given y
    OP_TANH_Y,  // 1-y*y from given y
    OP_VAL,     // pass value through (relu, zero)
    OP_RELU_D   // relu derivative of one
  } nau_op_t;

  typedef struct packed {
    nau_op_t                  op;
    logic                     neg;
    logic signed [DATA_W-1:0] value;
    logic [AX_W-1:0]          ax;
  } nau_item_t;

  typedef logic [TABLE_SEGMENTS:0][ENTRY_W-1:0] sig_rom_t;

  localparam logic [63:0] ROM_STEP = (64'd8 << 31) / TABLE_SEGMENTS;

  // shift-subtract divide, only used while building the table
  function automatic logic [63:0] nau_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(8k/segments) in Q0.16, exp by series then powers in Q0.31
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] q;
    rom  = '0;
    term = 64'd1 << 31;
    sum  = term;
    for (int n = 1; n <= 20; n++) begin
      term = nau_udiv((term * ROM_STEP) >> 31, 64'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = sum;
    p = 64'd1 << 31;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      q      = nau_udiv(64'd1 << 48, (64'd1 << 31) + p);
      rom[k] = ENTRY_W'((q + 64'd1) >> 1);
      p      = (p * e + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ----- hdl/nau_front.sv -----
module nau_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nau_pkg::KIND_W-1:0]       cfg_function_kind,
  input  logic [nau_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [nau_pkg::DATA_W-1:0] in_value,
  output nau_pkg::nau_item_t               item
);
  import nau_pkg::*;

  logic [KIND_W-1:0] kind_r;
  logic [AX_W-1:0]   vx;
  logic [AX_W-1:0]   av;
  logic              neg;
  logic              pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_SIGMOID;
    end else if (cfg_valid) begin
      kind_r <= cfg_function_kind;
    end
  end

  always_comb begin
    neg = in_value[DATA_W-1];
    pos = !neg && (in_value != '0);
    vx  = AX_W'(in_value);
    av  = neg ? (AX_W'(0) - vx) : vx;

    item.neg   = neg;
    item.value = in_value;
    item.ax    = (kind_r == KIND_TANH) ? (av << 1) : av;
    item.op    = OP_VAL;

    unique case (kind_r)
      KIND_SIGMOID: begin
        unique case (in_mode)
          MODE_APPLY: item.op = OP_SIG_F;
          MODE_DX:    item.op = OP_SIG_D;
          MODE_DY:    item.op = OP_SIG_Y;
          default:    item.value = '0;
        endcase
      end
      KIND_TANH: begin
        unique case (in_mode)
          MODE_APPLY: item.op = OP_TANH_F;
          MODE_DX:    item.op = OP_TANH_D;
          MODE_DY:    item.op = OP_TANH_Y;
          default:    item.value = '0;
        endcase
      end
      KIND_RELU: begin
        unique case (in_mode)
          MODE_APPLY: begin
            if (!pos) begin
              item.value = '0;
            end
          end
          MODE_DX, MODE_DY: begin
            if (pos) begin
              item.op = OP_RELU_D;
            end else begin
              item.value = '0;
            end
          end
          default: item.value = '0;
        endcase
      end
      default: item.value = '0;
    endcase
  end

endmodule

// ----- hdl/nau_queue.sv -----
module nau_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nau_pkg::nau_item_t din,
  output logic               full,
  input  logic               pop,
  output nau_pkg::nau_item_t dout,
  output logic               empty
);
  import nau_pkg::*;

  nau_item_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r;
  logic [QUEUE_AW-1:0] rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic [QUEUE_AW:0]   cnt_nxt;
  logic                wr;
  logic                rd;

  assign full  = (cnt_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ----- hdl/nau_back.sv -----
module nau_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  nau_pkg::nau_item_t                q_item,
  output logic                              q_pop,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic signed [nau_pkg::DATA_W-1:0] out_result
);
  import nau_pkg::*;

  localparam int V_W     = ENTRY_W + SEG_BITS + 1;
  localparam int S_W     = 31;
  localparam int SHR     = 16 + SEG_BITS - 30;
  localparam int SHR_DN  = (SHR > 0) ? SHR : 0;
  localparam int SHR_UP  = (SHR < 0) ? -SHR : 0;
  localparam int SH_TAB  = 60 - FRAC_BITS;
  localparam int SH_VAL  = FRAC_BITS;
  localparam int SAT_LIM = 8 << FRAC_BITS;

  localparam logic [63:0]        HALF_S    = (64'd1 << SHR_DN) >> 1;
  localparam logic [63:0]        HALF_TAB  = 64'd1 << (SH_TAB - 1);
  localparam logic [63:0]        HALF_VAL  = 64'd1 << (SH_VAL - 1);
  localparam logic [S_W-1:0]     ONE30     = S_W'(1) << 30;
  localparam logic [MUL_W-1:0]   ONE30_M   = MUL_W'(1) << 30;
  localparam logic [MUL_W-1:0]   ONE_F     = MUL_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0]  BIAS_TAB  = PROD_W'(1) << 60;
  localparam logic [PROD_W-1:0]  BIAS_VAL  = PROD_W'(1) << (2 * FRAC_BITS);
  localparam logic [ENTRY_W-1:0] ROM_LAST  = SIG_ROM[TABLE_SEGMENTS];
  localparam logic [DATA_W-1:0]  RES_MIN   = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic [DATA_W-1:0]  RES_MAX   = {1'b0, {(DATA_W - 1){1'b1}}};

  // credit: items in flight plus items in the result queue
  logic [OUTQ_AW:0] cnt_r;
  logic             issue;
  logic             deq;
  logic [5:0]       vld_r;

  // stage 1: table read
  logic [POS_W-1:0]          pos;
  logic [POS_W-SEG_BITS-1:0] idx_full;
  logic [IDX_W-1:0]          idx;
  logic [ENTRY_W-1:0]        lo;
  logic [ENTRY_W-1:0]        hi;
  nau_op_t                   p1_op_r;
  logic                      p1_neg_r;
  logic signed [DATA_W-1:0]  p1_value_r;
  logic                      p1_sat_r;
  logic [ENTRY_W-1:0]        p1_lo_r;
  logic [ENTRY_W-1:0]        p1_diff_r;
  logic [SEG_BITS-1:0]       p1_frac_r;

  // stage 2: interpolation
  nau_op_t                  p2_op_r;
  logic                     p2_neg_r;
  logic signed [DATA_W-1:0] p2_value_r;
  logic [V_W-1:0]           p2_v_r;

  // stage 3: operand forming
  logic [63:0]             s_full;
  logic [S_W-1:0]          s;
  logic [S_W-1:0]          ns;
  logic [S_W-1:0]          y;
  logic [S_W-1:0]          my;
  logic [MUL_W-1:0]        t;
  logic [MUL_W-1:0]        nt;
  logic [MUL_W-1:0]        vs;
  logic signed [MUL_W-1:0] ma;
  logic signed [MUL_W-1:0] mb;
  logic                    neg_f;
  logic                    bias_en;
  logic                    tab;
  logic signed [MUL_W-1:0] p3_ma_r;
  logic signed [MUL_W-1:0] p3_mb_r;
  logic                    p3_neg_r;
  logic                    p3_bias_r;
  logic                    p3_tab_r;

  // stage 4: product
  logic signed [PROD_W-1:0] p4_prod_r;
  logic                     p4_neg_r;
  logic                     p4_bias_r;
  logic                     p4_tab_r;

  // stage 5: bias
  logic [PROD_W-1:0]        bias;
  logic signed [PROD_W-1:0] p5_p_r;
  logic                     p5_neg_r;
  logic                     p5_tab_r;

  // stage 6: round and saturate
  logic              neg_p;
  logic [63:0]       base;
  logic [63:0]       sum;
  logic [63:0]       mag;
  logic [DATA_W-2:0] p6_mag_r;
  logic              p6_ovf_r;
  logic              p6_neg_r;
  logic [DATA_W-1:0] res;

  // result queue
  logic [DATA_W-1:0]  oq_mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wp_r;
  logic [OUTQ_AW-1:0] oq_rp_r;
  logic [OUTQ_AW:0]   oq_cnt_r;
  logic               wr;

  assign issue = !q_empty && (cnt_r < (OUTQ_AW + 1)'(OUTQ_DEPTH));
  assign q_pop = issue;
  assign out_empty = (oq_cnt_r == '0);
  assign deq = out_pop && !out_empty;
  assign wr  = vld_r[5];
  assign out_result = oq_mem_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      vld_r    <= '0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      cnt_r    <= cnt_r + (OUTQ_AW + 1)'(issue) - (OUTQ_AW + 1)'(deq);
      vld_r    <= {vld_r[4:0], issue};
      oq_cnt_r <= oq_cnt_r + (OUTQ_AW + 1)'(wr) - (OUTQ_AW + 1)'(deq);
      if (wr) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (deq) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
    end
  end

  // stage 1: segment index, fraction and the two neighboring entries
  always_comb begin
    pos      = POS_W'(q_item.ax) * POS_W'(TABLE_SEGMENTS);
    idx_full = pos[POS_W-1:SEG_BITS];
    idx      = (idx_full >= (POS_W - SEG_BITS)'(TABLE_SEGMENTS)) ?
               IDX_W'(TABLE_SEGMENTS - 1) : idx_full[IDX_W-1:0];
    lo       = SIG_ROM[ROM_AW'(idx)];
    hi       = SIG_ROM[ROM_AW'(idx) + 1'b1];
  end

  // stage 3: rescale to Q0.30 and pick multiplier operands
  always_comb begin
    s_full = ((64'(p2_v_r) << SHR_UP) + HALF_S) >> SHR_DN;
    s      = s_full[S_W-1:0];
    ns     = ONE30 - s;
    y      = p2_neg_r ? ns : s;
    my     = p2_neg_r ? s : ns;
    t      = {s, 1'b0} - ONE30_M;
    nt     = ONE30_M - {s, 1'b0};
    vs     = MUL_W'(p2_value_r);
    ma      = signed'(vs);
    mb      = signed'(ONE_F);
    neg_f   = 1'b0;
    bias_en = 1'b0;
    tab     = 1'b0;
    unique case (p2_op_r)
      OP_SIG_F: begin
        ma  = signed'({1'b0, y});
        mb  = signed'(ONE30_M);
        tab = 1'b1;
      end
      OP_SIG_D: begin
        ma  = signed'({1'b0, y});
        mb  = signed'({1'b0, my});
        tab = 1'b1;
      end
      OP_TANH_F: begin
        ma    = signed'(t);
        mb    = signed'(ONE30_M);
        neg_f = p2_neg_r;
        tab   = 1'b1;
      end
      OP_TANH_D: begin
        ma      = signed'(t);
        mb      = signed'(nt);
        bias_en = 1'b1;
        tab     = 1'b1;
      end
      OP_SIG_Y: begin
        mb = signed'(ONE_F - vs);
      end
      OP_TANH_Y: begin
        mb      = signed'(MUL_W'(0) - vs);
        bias_en = 1'b1;
      end
      OP_VAL: begin
        mb = signed'(ONE_F);
      end
      OP_RELU_D: begin
        ma = signed'(ONE_F);
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  // stage 5 bias pick; stage 6: magnitude with rounding folded into one add, then sign and clamp
  always_comb begin
    bias  = p4_bias_r ? (p4_tab_r ? BIAS_TAB : BIAS_VAL) : '0;
    neg_p = p5_p_r[PROD_W-1];
    base  = neg_p ? ~p5_p_r : p5_p_r;
    sum   = base + (p5_tab_r ? HALF_TAB : HALF_VAL) + 64'(neg_p);
    mag   = p5_tab_r ? (sum >> SH_TAB) : (sum >> SH_VAL);
    if (p6_neg_r) begin
      res = p6_ovf_r ? RES_MIN : (DATA_W'(0) - {1'b0, p6_mag_r});
    end else begin
      res = p6_ovf_r ? RES_MAX : {1'b0, p6_mag_r};
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r    <= q_item.op;
    p1_neg_r   <= q_item.neg;
    p1_value_r <= q_item.value;
    p1_sat_r   <= (q_item.ax >= AX_W'(SAT_LIM));
    p1_lo_r    <= lo;
    p1_diff_r  <= (hi >= lo) ? (hi - lo) : '0;
    p1_frac_r  <= pos[SEG_BITS-1:0];

    p2_op_r    <= p1_op_r;
    p2_neg_r   <= p1_neg_r;
    p2_value_r <= p1_value_r;
    p2_v_r     <= p1_sat_r ? (V_W'(ROM_LAST) << SEG_BITS) :
                  ((V_W'(p1_lo_r) << SEG_BITS) + V_W'(p1_diff_r) * V_W'(p1_frac_r));

    p3_ma_r   <= ma;
    p3_mb_r   <= mb;
    p3_neg_r  <= neg_f;
    p3_bias_r <= bias_en;
    p3_tab_r  <= tab;

    p4_prod_r <= p3_ma_r * p3_mb_r;
    p4_neg_r  <= p3_neg_r;
    p4_bias_r <= p3_bias_r;
    p4_tab_r  <= p3_tab_r;

    p5_p_r   <= p4_prod_r + signed'(bias);
    p5_neg_r <= p4_neg_r;
    p5_tab_r <= p4_tab_r;

    p6_mag_r <= mag[DATA_W-2:0];
    p6_ovf_r <= |mag[63:DATA_W-1];
    p6_neg_r <= p5_neg_r | neg_p;

    if (wr) begin
      oq_mem_r[oq_wp_r] <= res;
    end
  end

endmodule

// ----- hdl/neural_activation_unit.sv -----
// a result reaches the result ports through the back stages and the result queue
// throughput: one item per cycle, sustained while results are popped as they come
// the credit check against the 16-entry result queue is what stalls intake
// reset: function_kind returns to sigmoid and both queues empty; no clearing pass
module neural_activation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              push,
  output logic                              full,
  input  logic [nau_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [nau_pkg::DATA_W-1:0] in_value,
  // result items
  output logic                              empty,
  input  logic                              pop,
  output logic signed [nau_pkg::DATA_W-1:0] out_result,
  // function_kind register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nau_pkg::KIND_W-1:0]        cfg_function_kind
);
  import nau_pkg::*;

  // classified item from the front, queued for the back
  nau_item_t f_item;
  nau_item_t q_item;
  logic      q_empty;
  logic      q_pop;

  // front: holds function_kind, turns kind and mode into one operation,
  // passes relu apply, zero relu slopes and the unused codes on as a plain value
  nau_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_function_kind (cfg_function_kind),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .item              (f_item)
  );

  // short queue so intake and execution stall on their own
  nau_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  // back: table read, interpolation, one shared multiply, round and clamp,
  // then the result queue; an item is only issued when its result has a slot
  nau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_pop    (pop),
    .out_empty  (empty),
    .out_result (out_result)
  );

`ifndef SYNTHESIS
  // the back never pulls from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  // a full queue always has an item for the back
  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !q_empty)
    else $error("queue full but empty");

  // a taken item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !q_empty)
    else $error("accepted item missing from queue");
`endif

endmodule
